// ===== hw/rtl/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit chunk allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int MAX_CHUNKS = 64;
	localparam int CHUNK_AW   = $clog2(MAX_CHUNKS);
	localparam int COUNT_W    = $clog2(MAX_CHUNKS + 1);
	localparam int LEN_W      = 16;
	localparam int FREE_W     = 17;

	localparam logic [LEN_W-1:0] CHUNK_SIZE_RESET = 16'd100;

	localparam logic [1:0] STATUS_PLACED  = 2'd0;
	localparam logic [1:0] STATUS_NEW     = 2'd1;
	localparam logic [1:0] STATUS_TOOLONG = 2'd2;
	localparam logic [1:0] STATUS_FULL    = 2'd3;

	typedef struct packed {
		logic                en;
		logic [CHUNK_AW-1:0] addr;
		logic [FREE_W-1:0]   data;
	} free_wr_t;

endpackage

// ===== hw/rtl/ffca_free_mem.sv =====
// ----------------------------------------------------------------------------
// ffca_free_mem
// Free-slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffca_free_mem
	import ffca_pkg::*;
(
	input  logic                clk,
	input  free_wr_t            wr,
	input  logic [CHUNK_AW-1:0] rd_addr,
	output logic [FREE_W-1:0]   rd_data
);

	logic [FREE_W-1:0] mem_q [MAX_CHUNKS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/first_fit_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator
// Places each record in the first open chunk with room, else opens a chunk while one is free.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  request  | start / busy            | record_length
//  result   | done (one-cycle strobe) | chunk_index, slot_offset, status,
//           |                         | chunks_open
//  config   | cfg_valid / cfg_ready   | cfg_data (chunk_size)
//
// A too-long record, or one arriving with no chunk open, is answered in the
// next cycle without raising busy. Otherwise busy is raised and the free-slot
// memory is scanned one entry per cycle from chunk 0 until the first hit or
// the last open chunk, after which done is raised.
// Reset empties all chunks and loads chunk_size with 100. Results cannot be
// stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator
	import ffca_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [LEN_W-1:0]   record_length,
	output logic               done,
	output logic [5:0]         chunk_index,
	output logic [15:0]        slot_offset,
	output logic [1:0]         status,
	output logic [6:0]         chunks_open,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LEN_W-1:0]   cfg_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                state_q;
	logic [LEN_W-1:0]    chunk_size_q;
	logic [COUNT_W-1:0]  open_q;
	logic [FREE_W-1:0]   need_q;
	logic [CHUNK_AW-1:0] k_q;
	logic                done_q;
	logic [CHUNK_AW-1:0] idx_q;
	logic [15:0]         off_q;
	logic [1:0]          status_q;

	free_wr_t            wr;
	logic [CHUNK_AW-1:0] rd_addr;
	logic [FREE_W-1:0]   rd_data;

	logic [FREE_W-1:0]   need;
	logic                accept;
	logic                too_long;
	logic                hit;
	logic                last;
	logic                room;
	logic [FREE_W-1:0]   size_ext;
	logic [FREE_W-1:0]   used;

	ffca_free_mem u_free_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q == ST_SCAN);
	assign accept    = start && !busy;
	assign size_ext  = {1'b0, chunk_size_q};
	assign need      = {1'b0, record_length} + FREE_W'(1);
	assign too_long  = need > size_ext;
	assign hit       = rd_data >= need_q;
	assign last      = (COUNT_W'(k_q) + COUNT_W'(1)) == open_q;
	assign room      = open_q < COUNT_W'(MAX_CHUNKS);
	assign used      = size_ext - rd_data;

	always_comb begin
		rd_addr = '0;
		if (state_q == ST_SCAN) begin
			rd_addr = k_q + CHUNK_AW'(1);
		end
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = '0;
		wr.data = size_ext - need;
		case (state_q)
			ST_IDLE: begin
				if (accept && !too_long && open_q == '0) begin
					wr.en = 1'b1;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					wr.en   = 1'b1;
					wr.addr = k_q;
					wr.data = rd_data - need_q;
				end else if (last && room) begin
					wr.en   = 1'b1;
					wr.addr = open_q[CHUNK_AW-1:0];
					wr.data = size_ext - need_q;
				end
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			chunk_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (too_long) begin
							done_q <= 1'b1;
						end else if (open_q == '0) begin
							done_q <= 1'b1;
							open_q <= COUNT_W'(1);
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (!hit && room) begin
							open_q <= open_q + COUNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					need_q   <= need;
					k_q      <= '0;
					idx_q    <= '0;
					off_q    <= '0;
					status_q <= too_long ? STATUS_TOOLONG : STATUS_NEW;
				end
			end
			ST_SCAN: begin
				k_q <= k_q + CHUNK_AW'(1);
				if (hit) begin
					idx_q    <= k_q;
					off_q    <= used[15:0];
					status_q <= STATUS_PLACED;
				end else if (last && room) begin
					idx_q    <= open_q[CHUNK_AW-1:0];
					off_q    <= '0;
					status_q <= STATUS_NEW;
				end else begin
					idx_q    <= '0;
					off_q    <= '0;
					status_q <= STATUS_FULL;
				end
			end
			default: begin
				k_q <= '0;
			end
		endcase
	end

	assign done        = done_q;
	assign chunk_index = 6'(idx_q);
	assign slot_offset = off_q;
	assign status      = status_q;
	assign chunks_open = 7'(open_q);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("result strobe while scan still running");

	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("transfer neither answered nor scanned");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= COUNT_W'(MAX_CHUNKS))
		else $error("open chunk count beyond table depth");

	a_new_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_NEW) |-> (7'(chunk_index) + 7'd1 == chunks_open))
		else $error("new chunk index does not match open count");

endmodule

// ===== sim/ffca_placement_checker.sv =====
// ----------------------------------------------------------------------------
// ffca_placement_checker
// Scoreboard for the first-fit chunk allocator.
// Keeps its own chunk table and chunk size, predicts the placement of every
// record transfer, and compares each done strobe, field by field, with the
// oldest outstanding placement.
// ----------------------------------------------------------------------------
module ffca_placement_checker
	import ffca_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [LEN_W-1:0] record_length,
	input  logic             done,
	input  logic [5:0]       chunk_index,
	input  logic [15:0]      slot_offset,
	input  logic [1:0]       status,
	input  logic [6:0]       chunks_open,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [5:0]  chunk;
		logic [15:0] offset;
		logic [1:0]  code;
		logic [6:0]  opened;
	} placement_t;

	logic [FREE_W-1:0] room [MAX_CHUNKS];
	logic [LEN_W-1:0]  chunk_sz;
	int                open_cnt;
	int                results_seen;
	placement_t        placements_due [$];
	placement_t        want;

	function automatic placement_t place_record(input logic [LEN_W-1:0] len);
		placement_t        p;
		logic [FREE_W-1:0] need;
		logic [FREE_W-1:0] used;
		int                hit;
		p = '0;
		hit = -1;
		need = {1'b0, len} + 17'd1;
		if (need > {1'b0, chunk_sz}) begin
			p.code = STATUS_TOOLONG;
		end else begin
			for (int k = 0; k < open_cnt; k++) begin
				if (hit < 0 && room[k] >= need)
					hit = k;
			end
			if (hit >= 0) begin
				// offset wraps when the chunk size shrank below the free count
				used = {1'b0, chunk_sz} - room[hit];
				room[hit] = room[hit] - need;
				p.chunk = hit[5:0];
				p.offset = used[15:0];
				p.code = STATUS_PLACED;
			end else if (open_cnt < MAX_CHUNKS) begin
				room[open_cnt] = {1'b0, chunk_sz} - need;
				p.chunk = open_cnt[5:0];
				p.code = STATUS_NEW;
				open_cnt++;
			end else begin
				p.code = STATUS_FULL;
			end
		end
		p.opened = open_cnt[6:0];
		return p;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what, got,
			exp_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_sz = CHUNK_SIZE_RESET;
			open_cnt = 0;
			results_seen = 0;
			errors = 0;
			placements_due.delete();
		end else begin
			if (done) begin
				if (placements_due.size() == 0) begin
					report_mismatch("status with no record outstanding", status, -1);
				end else begin
					want = placements_due.pop_front();
					if (chunk_index !== want.chunk)
						report_mismatch("chunk_index", chunk_index, want.chunk);
					if (slot_offset !== want.offset)
						report_mismatch("slot_offset", slot_offset, want.offset);
					if (status !== want.code)
						report_mismatch("status", status, want.code);
					if (chunks_open !== want.opened)
						report_mismatch("chunks_open", chunks_open, want.opened);
				end
				results_seen++;
			end
			if (start && !busy)
				placements_due.push_back(place_record(record_length));
			if (cfg_valid && cfg_ready)
				chunk_sz = cfg_data;
		end
		pending = placements_due.size();
	end

endmodule

// ===== sim/tb_first_fit_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_chunk_allocator
// Testbench for the first-fit chunk allocator.
// Drives record transfers in random bursts, first a directed set covering
// exact fits, too-long records and chunk size changes with chunks open, then
// random phases at several chunk sizes, including 2 and 65535. A separate
// checker predicts every placement; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb_first_fit_chunk_allocator;
	import ffca_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 175;
	localparam int FILL_PHASE    = 6;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [LEN_W-1:0] record_length;
	logic             done;
	logic [5:0]       chunk_index;
	logic [15:0]      slot_offset;
	logic [1:0]       status;
	logic [6:0]       chunks_open;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	int errors;
	int pending;
	int quiet;
	int burst_left;
	int size_now;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	first_fit_chunk_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.record_length (record_length),
		.done          (done),
		.chunk_index   (chunk_index),
		.slot_offset   (slot_offset),
		.status        (status),
		.chunks_open   (chunks_open),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	ffca_placement_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.record_length (record_length),
		.done          (done),
		.chunk_index   (chunk_index),
		.slot_offset   (slot_offset),
		.status        (status),
		.chunks_open   (chunks_open),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_record(input logic [LEN_W-1:0] len);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		record_length <= len;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end the burst: pick the next burst length, then idle a while
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
			gap = $urandom_range(1, 15);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic set_chunk_size(input logic [LEN_W-1:0] cap);
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		size_now = cap;
	endtask

	function automatic int phase_size(input int ph);
		case (ph)
			0: return $urandom_range(20, 400);
			1: return 2;
			2: return 65535;
			3: return $urandom_range(3, 64);
			4: return $urandom_range(2, 65535);
			5: return CHUNK_SIZE_RESET;
			FILL_PHASE: return 65535;
			default: return $urandom_range(2, 1000);
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_length(input int cap, input int fill_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < fill_pct)
			return LEN_W'(cap - 1);
		if (roll < fill_pct + 5)
			return LEN_W'(cap);
		if (roll < fill_pct + 20)
			return LEN_W'($urandom);
		if (roll < fill_pct + 35)
			return LEN_W'($urandom_range(0, cap - 1));
		return LEN_W'($urandom_range(0, cap / 16));
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		record_length = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		size_now = CHUNK_SIZE_RESET;
		burst_left = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset chunk size: first record with nothing open, exact fills, too long
		send_record(16'd5);
		send_record(16'd0);
		send_record(16'd99);
		send_record(16'd100);
		send_record(16'hFFFF);
		send_record(16'd92);
		send_record(16'd0);
		send_record(16'd40);

		// grow with chunks open: old free counts kept
		set_chunk_size(16'hFFFF);
		send_record(16'hFFFE);
		send_record(16'hFFFF);
		send_record(16'd10);
		send_record(16'd1000);

		// shrink to a chunk size of 2 with chunks open: offset wraps
		set_chunk_size(16'd2);
		send_record(16'd0);
		send_record(16'd1);
		send_record(16'd2);
		send_record(16'hFFFF);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_chunk_size(LEN_W'(phase_size(ph)));
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_record(pick_length(size_now, (ph == FILL_PHASE) ? 50 : 8));
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100)
			@(negedge clk);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
